// ----- hw/rtl/utvf_pkg.sv -----
// constants and character classification functions of the utf-8 text field validator
// no dependencies; used by the channel interfaces and the core

package utvf_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CountW     = 8;
  localparam int unsigned MaxRepeatW = 4;
  localparam int unsigned CharBytesW = 32;
  localparam int unsigned CharLenW   = 3;
  localparam int unsigned ExtraW     = 2;

  localparam logic [CountW-1:0]     CountLimit     = 8'd255;
  localparam logic [MaxRepeatW-1:0] MaxRepeatReset = 4'd3;
  localparam logic [ByteW-1:0]      AccentLead     = 8'hC3;
  localparam logic [ByteW-1:0]      SpaceChar      = 8'h20;
  localparam logic [ByteW-1:0]      DigitLo        = 8'h30;
  localparam logic [ByteW-1:0]      DigitHi        = 8'h39;
  localparam logic [CharLenW-1:0]   MaxCharLen     = 3'd4;

  function automatic logic is_digit(input logic [ByteW-1:0] b);
    return (b >= DigitLo) && (b <= DigitHi);
  endfunction

  function automatic logic is_plain_allowed(input logic [ByteW-1:0] b, input logic spaces);
    logic ok;
    ok = is_digit(b) || (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    unique case (b)
      8'h5F, 8'h2D, 8'h2E, 8'h40, 8'h21, 8'h23, 8'h24,
      8'h25, 8'h26, 8'h2A, 8'h3F, 8'h2B, 8'h3D: ok = 1'b1;
      SpaceChar: ok = spaces;
      default: ok = ok;
    endcase
    return ok;
  endfunction

  function automatic logic is_accent_tail(input logic [ByteW-1:0] b);
    logic ok;
    unique case (b)
      8'hA1, 8'hA9, 8'hAD, 8'hB3, 8'hBA, 8'hBC, 8'h81,
      8'h89, 8'h8D, 8'h93, 8'h9A, 8'h9C, 8'hB1, 8'h91: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // continuation bytes that follow a lead byte
  function automatic logic [ExtraW-1:0] lead_extra(input logic [ByteW-1:0] b);
    logic [ExtraW-1:0] n;
    if (b[7] == 1'b0) n = 2'd0;
    else if (b[7:5] == 3'b110) n = 2'd1;
    else if (b[7:4] == 4'b1110) n = 2'd2;
    else if (b[7:3] == 5'b11110) n = 2'd3;
    else n = 2'd0;
    return n;
  endfunction

endpackage

// ----- hw/rtl/utvf_intf.sv -----
// valid/ready channel interfaces of the utf-8 text field validator
// depends on utvf_pkg

interface utvf_in_if
  import utvf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             allow_spaces;
  logic             last_byte;

  modport source (output valid, data_byte, allow_spaces, last_byte, input ready);
  modport sink   (input valid, data_byte, allow_spaces, last_byte, output ready);
endinterface

interface utvf_out_if
  import utvf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              chars_valid;
  logic              repeat_run_found;
  logic              double_space_found;
  logic              digits_only;
  logic [CountW-1:0] char_count;

  modport source (output valid, chars_valid, repeat_run_found, double_space_found,
                  digits_only, char_count, input ready);
  modport sink   (input valid, chars_valid, repeat_run_found, double_space_found,
                  digits_only, char_count, output ready);
endinterface

interface utvf_cfg_if
  import utvf_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [MaxRepeatW-1:0] max_repeat;

  modport source (output valid, max_repeat, input ready);
  modport sink   (input valid, max_repeat, output ready);
endinterface

// ----- hw/rtl/utf8_text_field_validator_core.sv -----
// utf-8 text field validator: byte input register, per-string check state, verdict register
// depends on utvf_pkg and the channel interfaces in utvf_intf.sv
// the final byte is held in the input register; the verdict register loads when that byte leaves it
// throughput: one byte per cycle, set by the single input register feeding the check logic
// a verdict waiting in the output register stalls the next final byte, and the input behind it
// reset: max_repeat returns to 3, all string state clears as at the start of a string

module utf8_text_field_validator_core
  import utvf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  utvf_in_if.sink    in_i,
  utvf_out_if.source out_o,
  utvf_cfg_if.sink   cfg_i
);

  logic [MaxRepeatW-1:0] max_rep_q;

  logic             s1_vld_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_sp_q;
  logic             s1_last_q;
  logic             s1_adv;

  logic                  pend_q, pend_d;
  logic                  ok_q, ok_d;
  logic                  prev_sp_q, prev_sp_d;
  logic                  dbl_q, dbl_d;
  logic                  dig_q, dig_d;
  logic [CountW-1:0]     cp_q, cp_d;
  logic [CharBytesW-1:0] prev_cur_q, prev_cur_d;
  logic [CharLenW-1:0]   prev_len_q, prev_len_d;
  logic [CharBytesW-1:0] cur_q, cur_d;
  logic [CharLenW-1:0]   len_q, len_d;
  logic [ExtraW-1:0]     bse_q, bse_d;
  logic [MaxRepeatW-1:0] run_q, run_d;
  logic                  exc_q, exc_d;
  logic                  fin, same;

  logic              out_vld_q;
  logic              o_valid_q, o_rep_q, o_dbl_q, o_dig_q;
  logic [CountW-1:0] o_cnt_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rep_q <= MaxRepeatReset;
    end else if (cfg_i.valid) begin
      max_rep_q <= cfg_i.max_repeat;
    end
  end

  assign s1_adv     = s1_vld_q && (!s1_last_q || !out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.data_byte;
      s1_sp_q   <= in_i.allow_spaces;
      s1_last_q <= in_i.last_byte;
    end
  end

  always_comb begin
    pend_d     = pend_q;
    ok_d       = ok_q;
    if (pend_q) begin
      pend_d = 1'b0;
      ok_d   = ok_q && is_accent_tail(s1_byte_q);
    end else if (!is_plain_allowed(s1_byte_q, s1_sp_q)) begin
      if (s1_byte_q == AccentLead) pend_d = 1'b1;
      else ok_d = 1'b0;
    end

    dbl_d     = dbl_q || (prev_sp_q && s1_byte_q == SpaceChar);
    prev_sp_d = (s1_byte_q == SpaceChar);
    dig_d     = dig_q && is_digit(s1_byte_q);
    cp_d      = (s1_byte_q[7:6] != 2'b10 && cp_q < CountLimit) ? cp_q + 8'd1 : cp_q;

    if (bse_q == '0) begin
      cur_d = {24'b0, s1_byte_q};
      len_d = 3'd1;
      bse_d = lead_extra(s1_byte_q);
    end else begin
      cur_d = cur_q | ({24'b0, s1_byte_q} << {len_q[1:0], 3'b000});
      len_d = len_q + 3'd1;
      bse_d = bse_q - 2'd1;
    end

    fin        = (bse_d == '0) || s1_last_q;
    same       = (prev_len_q == len_d) && (prev_cur_q == cur_d);
    run_d      = run_q;
    exc_d      = exc_q;
    prev_cur_d = prev_cur_q;
    prev_len_d = prev_len_q;
    if (fin) begin
      if (same) begin
        if (run_q >= max_rep_q) exc_d = 1'b1;
        else run_d = run_q + 4'd1;
      end else begin
        run_d = 4'd1;
      end
      prev_cur_d = cur_d;
      prev_len_d = len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= 1'b0;
      ok_q       <= 1'b1;
      prev_sp_q  <= 1'b0;
      dbl_q      <= 1'b0;
      dig_q      <= 1'b1;
      cp_q       <= '0;
      prev_cur_q <= '0;
      prev_len_q <= '0;
      cur_q      <= '0;
      len_q      <= '0;
      bse_q      <= '0;
      run_q      <= 4'd1;
      exc_q      <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        pend_q     <= 1'b0;
        ok_q       <= 1'b1;
        prev_sp_q  <= 1'b0;
        dbl_q      <= 1'b0;
        dig_q      <= 1'b1;
        cp_q       <= '0;
        prev_cur_q <= '0;
        prev_len_q <= '0;
        cur_q      <= '0;
        len_q      <= '0;
        bse_q      <= '0;
        run_q      <= 4'd1;
        exc_q      <= 1'b0;
      end else begin
        pend_q     <= pend_d;
        ok_q       <= ok_d;
        prev_sp_q  <= prev_sp_d;
        dbl_q      <= dbl_d;
        dig_q      <= dig_d;
        cp_q       <= cp_d;
        prev_cur_q <= prev_cur_d;
        prev_len_q <= prev_len_d;
        cur_q      <= cur_d;
        len_q      <= len_d;
        bse_q      <= fin ? '0 : bse_d;
        run_q      <= run_d;
        exc_q      <= exc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      o_valid_q <= ok_d && !pend_d;
      o_rep_q   <= exc_d;
      o_dbl_q   <= dbl_d;
      o_dig_q   <= dig_d;
      o_cnt_q   <= cp_d;
    end
  end

  assign out_o.valid              = out_vld_q;
  assign out_o.chars_valid        = o_valid_q;
  assign out_o.repeat_run_found   = o_rep_q;
  assign out_o.double_space_found = o_dbl_q;
  assign out_o.digits_only        = o_dig_q;
  assign out_o.char_count         = o_cnt_q;

`ifndef SYNTHESIS
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q != 4'd0)
    else $error("run length reached zero");

  a_prev_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prev_len_q <= MaxCharLen)
    else $error("stored character longer than four bytes");

  a_digits_are_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_o.digits_only |-> out_o.chars_valid)
    else $error("digit-only verdict marked invalid");

  a_count_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !s1_last_q |=> cp_q >= $past(cp_q))
    else $error("code point count decreased within a string");
`endif

endmodule

// ----- tb/utvf_verdict_checker.sv -----
// verdict checker of the utf-8 text field validator: predicts each string verdict from the
// observed byte and max_repeat transactions and compares each verdict with it field by field
// depends on utvf_pkg and the channel interfaces in utvf_intf.sv

module utvf_verdict_checker
  import utvf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  utvf_in_if          in_i,
  utvf_out_if         res_i,
  utvf_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned verdict_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              chars_valid;
    logic              repeat_run_found;
    logic              double_space_found;
    logic              digits_only;
    logic [CountW-1:0] char_count;
  } verdict_t;

  verdict_t expected_verdicts[$];
  verdict_t got;
  verdict_t want;

  logic [MaxRepeatW-1:0] repeat_limit;
  logic                  accent_open;
  logic                  set_ok;
  logic                  last_space;
  logic                  dbl_space;
  logic                  digits_ok;
  logic                  run_hit;
  logic [CountW-1:0]     cp_count;
  logic [CharBytesW-1:0] prev_ch;
  logic [CharBytesW-1:0] cur_ch;
  logic [CharLenW-1:0]   prev_len;
  logic [CharLenW-1:0]   cur_len;
  logic [CharLenW-1:0]   tail_left;
  logic [MaxRepeatW-1:0] run_len;

  function automatic logic in_char_set(input logic [ByteW-1:0] b, input logic spaces);
    if (b == SpaceChar) return spaces;
    return b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], 8'h21, 8'h23, 8'h24,
                     8'h25, 8'h26, 8'h2A, 8'h2B, 8'h2D, 8'h2E, 8'h3D, 8'h3F, 8'h40, 8'h5F};
  endfunction

  function automatic logic spanish_tail(input logic [ByteW-1:0] b);
    return b inside {8'h81, 8'h89, 8'h8D, 8'h91, 8'h93, 8'h9A, 8'h9C,
                     8'hA1, 8'hA9, 8'hAD, 8'hB1, 8'hB3, 8'hBA, 8'hBC};
  endfunction

  function automatic logic [CharLenW-1:0] seq_bytes(input logic [ByteW-1:0] b);
    casez (b)
      8'b0???????: return 3'd1;
      8'b110?????: return 3'd2;
      8'b1110????: return 3'd3;
      8'b11110???: return 3'd4;
      default:     return 3'd1;
    endcase
  endfunction

  function automatic void clear_string();
    accent_open = 1'b0;
    set_ok      = 1'b1;
    last_space  = 1'b0;
    dbl_space   = 1'b0;
    digits_ok   = 1'b1;
    cp_count    = '0;
    prev_ch     = '0;
    prev_len    = '0;
    cur_ch      = '0;
    cur_len     = '0;
    tail_left   = '0;
    run_len     = 4'd1;
    run_hit     = 1'b0;
  endfunction

  function automatic void close_char();
    if (prev_len == cur_len && prev_ch == cur_ch) begin
      if (run_len >= repeat_limit) run_hit = 1'b1;
      else run_len = run_len + 4'd1;
    end else begin
      run_len = 4'd1;
    end
    prev_ch   = cur_ch;
    prev_len  = cur_len;
    tail_left = '0;
  endfunction

  function automatic void take_byte(input logic [ByteW-1:0] b, input logic spaces,
                                    input logic last);
    verdict_t v;
    if (accent_open) begin
      accent_open = 1'b0;
      if (!spanish_tail(b)) set_ok = 1'b0;
    end else if (!in_char_set(b, spaces)) begin
      if (b == AccentLead) accent_open = 1'b1;
      else set_ok = 1'b0;
    end
    if (b == SpaceChar && last_space) dbl_space = 1'b1;
    last_space = (b == SpaceChar);
    if (b < DigitLo || b > DigitHi) digits_ok = 1'b0;
    if (b[7:6] != 2'b10 && cp_count < CountLimit) cp_count = cp_count + 8'd1;
    if (tail_left == '0) begin
      cur_ch    = CharBytesW'(b);
      cur_len   = 3'd1;
      tail_left = seq_bytes(b) - 3'd1;
    end else begin
      cur_ch    = cur_ch | (CharBytesW'(b) << {cur_len[1:0], 3'b000});
      cur_len   = cur_len + 3'd1;
      tail_left = tail_left - 3'd1;
    end
    if (tail_left == '0 || last) close_char();
    if (last) begin
      v = {set_ok && !accent_open, run_hit, dbl_space, digits_ok, cp_count};
      expected_verdicts.push_back(v);
      clear_string();
    end
  endfunction

  function automatic void compare_field(input string field, input int unsigned exp_val,
                                        input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_limit = MaxRepeatReset;
      clear_string();
      expected_verdicts.delete();
      fail_count_o    = 0;
      pending_o       = 0;
      verdict_count_o = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got = {res_i.chars_valid, res_i.repeat_run_found, res_i.double_space_found,
               res_i.digits_only, res_i.char_count};
        if (expected_verdicts.size() == 0) begin
          $display("%0t: verdict with none expected, actual %p", $time, got);
          fail_count_o++;
        end else begin
          want = expected_verdicts.pop_front();
          compare_field("chars_valid", want.chars_valid, got.chars_valid);
          compare_field("repeat_run_found", want.repeat_run_found, got.repeat_run_found);
          compare_field("double_space_found", want.double_space_found,
                        got.double_space_found);
          compare_field("digits_only", want.digits_only, got.digits_only);
          compare_field("char_count", want.char_count, got.char_count);
          verdict_count_o++;
        end
      end
      if (cfg_i.valid && cfg_i.ready) repeat_limit = cfg_i.max_repeat;
      if (in_i.valid && in_i.ready) take_byte(in_i.data_byte, in_i.allow_spaces, in_i.last_byte);
      pending_o = expected_verdicts.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// top of the utf-8 text field validator testbench: clock, reset, byte and verdict traffic,
// max_repeat writes between phases, and the final verdict
// depends on utvf_pkg, utvf_intf.sv, the core and utvf_verdict_checker

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import utvf_pkg::*;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned PhaseItems    = 200;
  localparam int unsigned HoldOffAt     = 20;
  localparam int unsigned HoldOffCycles = 250;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             spaces;
    logic             last;
  } byte_item_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  byte_item_t  stim_q[$];
  string       punct_set = "_-.@!#$%&*?+=";
  int unsigned bytes_sent    = 0;
  int unsigned strings_built = 0;
  int unsigned settings_used = 0;
  int unsigned send_mode     = 0;
  int unsigned cycles        = 0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned verdicts;

  utvf_in_if  in_ch ();
  utvf_out_if res_ch ();
  utvf_cfg_if cfg_ch ();

  utf8_text_field_validator_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  utvf_verdict_checker verdict_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_i            (in_ch),
    .res_i           (res_ch),
    .cfg_i           (cfg_ch),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .verdict_count_o (verdicts)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL utf8_text_field_validator_core");
      $finish;
    end
  end

  function automatic logic [ByteW-1:0] accent_tail(input int unsigned k);
    case (k)
      0:  return 8'hA1;
      1:  return 8'hA9;
      2:  return 8'hAD;
      3:  return 8'hB3;
      4:  return 8'hBA;
      5:  return 8'hBC;
      6:  return 8'h81;
      7:  return 8'h89;
      8:  return 8'h8D;
      9:  return 8'h93;
      10: return 8'h9A;
      11: return 8'h9C;
      12: return 8'hB1;
      default: return 8'h91;
    endcase
  endfunction

  function automatic void push_byte(input logic [ByteW-1:0] b, input logic sp, input logic last);
    stim_q.push_back('{data: b, spaces: sp, last: last});
    if (last) strings_built++;
  endfunction

  function automatic void add_text(input string s, input logic sp);
    for (int k = 0; k < s.len(); k++) push_byte(s[k], sp, k == s.len() - 1);
  endfunction

  function automatic void add_random_string(input int unsigned len, input logic run_heavy);
    logic [ByteW-1:0] text[$];
    logic [ByteW-1:0] ch[$];
    int unsigned      space_mode;
    int unsigned      kind;
    logic             digit_str;
    logic             sp;
    logic             fresh;
    space_mode = $urandom_range(0, 2);
    digit_str  = ($urandom_range(0, 7) == 0);
    while (text.size() < len) begin
      fresh = run_heavy ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 2) != 0);
      if (ch.size() == 0 || fresh) begin
        ch.delete();
        kind = digit_str ? 0 : $urandom_range(0, 19);
        if (kind < 5) begin
          ch.push_back(DigitLo + 8'($urandom_range(0, 9)));
        end else if (kind < 9) begin
          ch.push_back(($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25)));
        end else if (kind < 11) begin
          ch.push_back(punct_set[$urandom_range(0, punct_set.len() - 1)]);
        end else if (kind < 13) begin
          ch.push_back(SpaceChar);
        end else if (kind < 15) begin
          ch.push_back(AccentLead);
          ch.push_back(accent_tail($urandom_range(0, 13)));
        end else if (kind == 15) begin
          ch.push_back(AccentLead);
          ch.push_back(8'($urandom_range(0, 255)));
        end else if (kind == 16) begin
          ch.push_back({4'b1110, 4'($urandom_range(0, 15))});
          repeat (2) ch.push_back({2'b10, 6'($urandom_range(0, 63))});
        end else if (kind == 17) begin
          ch.push_back({5'b11110, 3'($urandom_range(0, 7))});
          repeat (3) ch.push_back({2'b10, 6'($urandom_range(0, 63))});
        end else if (kind == 18) begin
          ch.push_back(8'($urandom_range(0, 255)));
        end else begin
          ch.push_back({2'b10, 6'($urandom_range(0, 63))});
        end
      end
      foreach (ch[k]) text.push_back(ch[k]);
    end
    for (int unsigned k = 0; k < len; k++) begin
      case (space_mode)
        0:       sp = 1'b0;
        1:       sp = 1'b1;
        default: sp = 1'($urandom_range(0, 1));
      endcase
      push_byte(text[k], sp, k == len - 1);
    end
  endfunction

  task automatic drive_items();
    byte_item_t  it;
    int unsigned gap;
    while (stim_q.size() != 0) begin
      it = stim_q.pop_front();
      if (bytes_sent % 32 == 0) send_mode = $urandom_range(0, 2);
      gap = (send_mode == 0) ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_ch.valid        = 1'b1;
      in_ch.data_byte    = it.data;
      in_ch.allow_spaces = it.spaces;
      in_ch.last_byte    = it.last;
      do @(posedge clk); while (!in_ch.ready);
      bytes_sent++;
      @(negedge clk);
    end
    in_ch.valid = 1'b0;
  endtask

  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [MaxRepeatW-1:0] v);
    cfg_ch.valid      = 1'b1;
    cfg_ch.max_repeat = v;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    settings_used++;
  endtask

  // verdict sink with random stalls and one long hold-off
  initial begin
    int unsigned taken;
    int unsigned wait_cycles;
    int unsigned recv_mode;
    taken        = 0;
    recv_mode    = 1;
    res_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (taken % 8 == 0) recv_mode = $urandom_range(0, 2);
      if (taken == HoldOffAt) wait_cycles = HoldOffCycles;
      else wait_cycles = (recv_mode == 0) ? 0 : $urandom_range(0, 17);
      if (wait_cycles != 0) begin
        res_ch.ready = 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      res_ch.ready = 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      taken++;
    end
  end

  initial begin
    logic [MaxRepeatW-1:0] lim;
    int unsigned           len;
    logic                  heavy;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.allow_spaces = 1'b0;
    in_ch.last_byte    = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.max_repeat  = MaxRepeatReset;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed strings at the reset max_repeat
    add_text("09", 1'b0);
    add_text("a@Z.", 1'b0);
    add_text("x  y", 1'b1);
    add_text(" ", 1'b0);
    push_byte(8'h61, 1'b0, 1'b0);
    push_byte(SpaceChar, 1'b1, 1'b0);
    push_byte(SpaceChar, 1'b0, 1'b1);
    push_byte(AccentLead, 1'b0, 1'b0);
    push_byte(8'hB1, 1'b0, 1'b1);
    push_byte(AccentLead, 1'b0, 1'b0);
    push_byte(8'h41, 1'b0, 1'b1);
    push_byte(8'h61, 1'b0, 1'b0);
    push_byte(AccentLead, 1'b0, 1'b1);
    push_byte(8'hE2, 1'b1, 1'b0);
    push_byte(8'h82, 1'b1, 1'b1);
    push_byte(8'h00, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b1);
    add_text("aaaa", 1'b0);
    drive_items();
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       lim = 4'd0;
        1:       lim = 4'd15;
        2:       lim = 4'd1;
        default: lim = 4'($urandom_range(0, 15));
      endcase
      write_limit(lim);
      // one string longer in bytes than the code point count limit
      if (ph == 1) add_random_string($urandom_range(290, 320), 1'b0);
      while (stim_q.size() < PhaseItems) begin
        heavy = ($urandom_range(0, 5) == 0);
        len   = heavy ? $urandom_range(1, 24) : $urandom_range(1, 12);
        add_random_string(len, heavy);
      end
      drive_items();
      settle();
    end

    $display("sent %0d bytes in %0d strings under %0d max_repeat writes, %0d verdicts checked",
             bytes_sent, strings_built, settings_used, verdicts);
    $display("covered accent pairs, dangling leads, cut multi-byte chars, spaces and runs");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS utf8_text_field_validator_core");
    end else begin
      $display("FAIL utf8_text_field_validator_core");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/utvf_pkg.sv
hw/rtl/utvf_intf.sv
hw/rtl/utf8_text_field_validator_core.sv
tb/utvf_verdict_checker.sv
tb/testbench.sv
